FILE: design/fqs_pkg.sv
package fqs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_FIND = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } stat_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic tok_load;
    logic tok_shift;
  } cell_ctl_t;

endpackage

FILE: design/fifo_queue_with_search.sv
// Channel   Ports                                               Transfer
// input     start, busy, in_op, in_value                        start && !busy
// result    out_strobe, out_status, out_popped_value,           out_strobe
//           out_found_index, out_entry_count
//
// Push, pop, unused op, find on an empty queue: result in the cycle after the transfer.
// Find: a search token starts in cell 0 and walks the row one cell per cycle; the
// result is registered on a match, or at the last held entry if the key is absent.
// Reset (synchronous, rst_n low) empties the queue; entry storage is not cleared.
// busy is high while a search runs; results cannot be held off by the receiver.
module fifo_queue_with_search
  import fqs_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IDX_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_op,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  out_strobe,
  output logic [STAT_W-1:0]     out_status,
  output logic [DATA_WIDTH-1:0] out_popped_value,
  output logic [IDX_W-1:0]      out_found_index,
  output logic [CNT_W-1:0]      out_entry_count
);

  state_t                state_r;
  state_t                state_nxt;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      idx_nxt;
  logic [DATA_WIDTH-1:0] key_r;
  logic                  strobe_r;
  logic [STAT_W-1:0]     status_r;
  logic [DATA_WIDTH-1:0] popped_r;
  logic [IDX_W-1:0]      fidx_r;
  logic [CNT_W-1:0]      ocount_r;

  logic                  accept;
  logic                  hit;
  logic                  last;
  cell_ctl_t             ctl;
  logic                  res_vld;
  stat_t                 res_status;
  logic [DATA_WIDTH-1:0] res_popped;
  logic [IDX_W-1:0]      res_idx;

  logic [DATA_WIDTH-1:0] data_w [DEPTH];
  logic [DEPTH-1:0]      tok_w;
  logic [DEPTH-1:0]      match_w;

  assign busy   = (state_r == ST_SCAN);
  assign accept = start && !busy;
  assign hit    = |match_w;
  assign last   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (op_t'(in_op) == OP_FIND) && (count_r != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl        = '0;
    res_vld    = 1'b0;
    res_status = STAT_OK;
    res_popped = '0;
    res_idx    = '0;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_vld = 1'b1;
          case (op_t'(in_op))
            OP_PUSH: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_status = STAT_FULL;
              end else begin
                ctl.push  = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                ctl.pop    = 1'b1;
                res_popped = data_w[0];
                count_nxt  = count_r - CNT_W'(1);
              end
            end
            OP_FIND: begin
              if (count_r == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_vld      = 1'b0;
                ctl.tok_load = 1'b1;
                idx_nxt      = '0;
              end
            end
            default: res_status = STAT_OK;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_vld = 1'b1;
          res_idx = idx_r;
        end else if (last) begin
          res_vld    = 1'b1;
          res_status = STAT_NOTFOUND;
        end else begin
          ctl.tok_shift = 1'b1;
          idx_nxt       = idx_r + IDX_W'(1);
        end
      end
      default: res_vld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (accept) begin
      key_r <= in_value;
    end
    if (res_vld) begin
      status_r <= res_status;
      popped_r <= res_popped;
      fidx_r   <= res_idx;
      ocount_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nd;
    logic                  pt;
    if (i == DEPTH - 1) begin : g_end
      assign nd = data_w[i];
    end else begin : g_mid
      assign nd = data_w[i+1];
    end
    if (i == 0) begin : g_first
      assign pt = 1'b0;
    end else begin : g_rest
      assign pt = tok_w[i-1];
    end
    fqs_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .count      (count_r),
      .push_value (in_value),
      .next_data  (nd),
      .prev_tok   (pt),
      .key        (key_r),
      .data       (data_w[i]),
      .tok        (tok_w[i]),
      .match      (match_w[i])
    );
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_found_index  = fidx_r;
  assign out_entry_count  = ocount_r;

endmodule

FILE: design/fqs_cell.sv
module fqs_cell
  import fqs_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctl_t             ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] push_value,
  input  logic [DATA_WIDTH-1:0] next_data,
  input  logic                  prev_tok,
  input  logic [DATA_WIDTH-1:0] key,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  tok,
  output logic                  match
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  tok_r;
  logic                  tok_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.push && (count == CNT_W'(IDX))) begin
      data_nxt = push_value;
    end else if (ctl.pop) begin
      data_nxt = next_data;
    end
  end

  always_comb begin
    if (ctl.tok_load) begin
      tok_nxt = (IDX == 0);
    end else if (ctl.tok_shift) begin
      tok_nxt = prev_tok;
    end else begin
      tok_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign data  = data_r;
  assign tok   = tok_r;
  assign match = tok_r && (data_r == key);

endmodule

FILE: tb/sv/fifo_queue_with_search_tb.sv
module fifo_queue_with_search_tb;
  import fqs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QD    = DEPTH_DEF;
  localparam int DW    = DATA_WIDTH_DEF;
  localparam int CNT_W = $clog2(QD + 1);
  localparam int IDX_W = $clog2(QD);

  typedef struct {
    stat_t             status;
    logic [DW-1:0]     popped;
    logic [IDX_W-1:0]  index;
    logic [CNT_W-1:0]  count;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [OP_W-1:0]   in_op = OP_PUSH;
  logic [DW-1:0]     in_value = '0;
  logic              busy;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [DW-1:0]     out_popped_value;
  logic [IDX_W-1:0]  out_found_index;
  logic [CNT_W-1:0]  out_entry_count;

  logic [DW-1:0]     mirror_mem [QD];
  logic [IDX_W-1:0]  mirror_head = '0;
  logic [IDX_W-1:0]  mirror_tail = '0;
  logic [CNT_W-1:0]  mirror_count = '0;

  reply_t pending_replies [$];
  int     idle_pct = 0;
  int     mismatch_cnt = 0;

  fifo_queue_with_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_found_index  (out_found_index),
    .out_entry_count  (out_entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic reply_t queue_apply(op_t op, logic [DW-1:0] val);
    reply_t           r;
    logic [IDX_W-1:0] p;
    r.status = STAT_OK;
    r.popped = '0;
    r.index  = '0;
    case (op)
      OP_PUSH: begin
        if (mirror_count >= QD) begin
          r.status = STAT_FULL;
        end else begin
          mirror_mem[mirror_tail] = val;
          mirror_tail  = mirror_tail + 1'b1;
          mirror_count = mirror_count + 1'b1;
        end
      end
      OP_POP: begin
        if (mirror_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped     = mirror_mem[mirror_head];
          mirror_head  = mirror_head + 1'b1;
          mirror_count = mirror_count - 1'b1;
        end
      end
      OP_FIND: begin
        if (mirror_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.status = STAT_NOTFOUND;
          p = mirror_head;
          for (int i = 0; i < mirror_count; i++) begin
            if (mirror_mem[p] == val) begin
              r.status = STAT_OK;
              r.index  = IDX_W'(i);
              break;
            end
            p = p + 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.count = mirror_count;
    return r;
  endfunction

  task automatic send_req(op_t op, logic [DW-1:0] val);
    start    <= 1'b1;
    in_op    <= op;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_replies.push_back(queue_apply(op, val));
    if ($urandom_range(99) < idle_pct) begin
      start    <= 1'b0;
      in_op    <= OP_W'($urandom);
      in_value <= DW'($urandom);
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_strobe) begin
      if (pending_replies.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d popped %h index %0d count %0d",
                   out_status, out_popped_value, out_found_index, out_entry_count);
      end else begin
        e = pending_replies.pop_front();
        if (out_status !== e.status || out_popped_value !== e.popped ||
            out_found_index !== e.index || out_entry_count !== e.count) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp status %0d popped %h index %0d count %0d, got %0d %h %0d %0d",
                     e.status, e.popped, e.index, e.count,
                     out_status, out_popped_value, out_found_index, out_entry_count);
        end
      end
    end
  end

  task automatic test_empty_ops();
    send_req(OP_POP, 32'h1234_5678);
    send_req(OP_FIND, '0);
    send_req(OP_NONE, '1);
  endtask

  task automatic test_extremes();
    send_req(OP_PUSH, '0);
    send_req(OP_PUSH, '1);
    send_req(OP_FIND, '1);
    send_req(OP_FIND, '0);
    send_req(OP_FIND, 32'h5555_AAAA);
    send_req(OP_NONE, 32'hA5A5_5A5A);
    send_req(OP_POP, '0);
    send_req(OP_POP, '1);
    send_req(OP_FIND, '1);
    send_req(OP_POP, '0);
  endtask

  task automatic test_full();
    for (int i = 0; i < QD; i++)
      send_req(OP_PUSH, 32'h1000_0000 + i);
    send_req(OP_PUSH, 32'hDEAD_BEEF);
    send_req(OP_FIND, 32'h1000_0000 + QD - 1);
    send_req(OP_FIND, 32'hDEAD_BEEF);
  endtask

  task automatic test_random(int n, int idle);
    int            r;
    int            push_bias;
    op_t           op;
    logic [DW-1:0] val;
    logic [IDX_W-1:0] p;
    idle_pct  = idle;
    push_bias = 45;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) begin
        case ($urandom_range(2))
          0: push_bias = 20;
          1: push_bias = 45;
          default: push_bias = 70;
        endcase
      end
      r = $urandom_range(99);
      if (r < 4) op = OP_NONE;
      else if (r < 4 + push_bias) op = OP_PUSH;
      else if (r < 4 + push_bias + (96 - push_bias) / 2) op = OP_POP;
      else op = OP_FIND;
      val = $urandom;
      if (op == OP_PUSH && $urandom_range(3) == 0) begin
        val = $urandom_range(7);
      end else if (op == OP_FIND) begin
        if (mirror_count != 0 && $urandom_range(9) < 7) begin
          p   = mirror_head + IDX_W'($urandom_range(mirror_count - 1));
          val = mirror_mem[p];
        end else if ($urandom_range(1) == 0) begin
          val = $urandom_range(7);
        end
      end
      send_req(op, val);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_ops();
    test_extremes();
    test_full();
    test_random(150, 0);
    drain_replies();
    test_random(150, 86);
    drain_replies();
    test_random(150, 23);
    drain_replies();
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && pending_replies.size() == 0) begin
      $display("fifo_queue_with_search_tb OK");
    end else begin
      $display("fifo_queue_with_search_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("fifo_queue_with_search_tb NOT OK");
    $finish;
  end

endmodule

FILE: files.f
design/fqs_pkg.sv
design/fqs_cell.sv
design/fifo_queue_with_search.sv
tb/sv/fifo_queue_with_search_tb.sv
